### sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared codes and types for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int OCT_BITS = 3;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam logic [OCT_BITS-1:0] OCT_FIRST = 3'd0;
	localparam logic [OCT_BITS-1:0] OCT_LAST  = 3'd7;

	// walker -> emitter: load a new step record
	typedef struct packed {
		logic load;
		logic done;
	} rec_ctl_t;

endpackage

### sv/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr_in_if / mcr_out_if
// Valid/ready channels for request items and point results.
// ----------------------------------------------------------------------------
interface mcr_in_if #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [COORD_BITS-1:0]  origin_x;
	logic signed [COORD_BITS-1:0]  origin_y;
	logic        [RADIUS_BITS-1:0] radius;

	modport source (output valid, req_type, origin_x, origin_y, radius, input ready);
	modport sink   (input valid, req_type, origin_x, origin_y, radius, output ready);
endinterface

interface mcr_out_if #(
	parameter int OUT_BITS = 13
);
	logic                        valid;
	logic                        ready;
	logic signed [OUT_BITS-1:0]  point_x;
	logic signed [OUT_BITS-1:0]  point_y;
	logic [mcr_pkg::OCT_BITS-1:0] octant;
	logic                        last_of_step;
	logic                        circle_done;

	modport source (output valid, point_x, point_y, octant, last_of_step, circle_done,
		input ready);
	modport sink   (input valid, point_x, point_y, octant, last_of_step, circle_done,
		output ready);
endinterface

### sv/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Integer midpoint circle walker emitting eight mirrored points per step.
// ----------------------------------------------------------------------------
// A start request latches center and radius and produces no points; a radius
// of zero leaves no circle active. Each step request on an active circle
// yields eight point transactions (octant 0..7) after it passes the input
// register and the step record register. Start requests and steps with no
// active circle retire without waiting on the point output. A single point
// output carries the eight points of a step; the next step is already computed
// and waits in the input register while the current one drains.
module midpoint_circle_rasterizer #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	mcr_in_if.sink     in_ch,
	mcr_out_if.source  out_ch
);
	mcr_pkg::rec_ctl_t             rec_ctl;
	logic                          rec_free;
	logic signed [COORD_BITS-1:0]  rec_cx;
	logic signed [COORD_BITS-1:0]  rec_cy;
	logic        [RADIUS_BITS-1:0] rec_x;
	logic        [RADIUS_BITS-1:0] rec_y;

	mcr_walk #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.rec_free (rec_free),
		.rec_ctl  (rec_ctl),
		.rec_cx   (rec_cx),
		.rec_cy   (rec_cy),
		.rec_x    (rec_x),
		.rec_y    (rec_y)
	);

	mcr_emit #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_ctl  (rec_ctl),
		.rec_cx   (rec_cx),
		.rec_cy   (rec_cy),
		.rec_x    (rec_x),
		.rec_y    (rec_y),
		.rec_free (rec_free),
		.out_ch   (out_ch)
	);

	// a step record never overwrites one that is still draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rec_ctl.load |-> rec_free)
		else $error("step record loaded while previous step still pending");

	// points of a step come back to back in the record until the eighth
	a_step_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_of_step) |=> out_ch.valid)
		else $error("step ended before its eighth point");

	a_done_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_of_step)
		|=> (out_ch.circle_done == $past(out_ch.circle_done)))
		else $error("done mark changed within a step");

endmodule

### sv/mcr_walk.sv
// ----------------------------------------------------------------------------
// mcr_walk
// Input register and circle walk state; one request retires per cycle unless a step waits for a free step record.
// ----------------------------------------------------------------------------
module mcr_walk #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mcr_in_if.sink                        in_ch,
	input  logic                          rec_free,
	output mcr_pkg::rec_ctl_t             rec_ctl,
	output logic signed [COORD_BITS-1:0]  rec_cx,
	output logic signed [COORD_BITS-1:0]  rec_cy,
	output logic        [RADIUS_BITS-1:0] rec_x,
	output logic        [RADIUS_BITS-1:0] rec_y
);
	localparam int XW = RADIUS_BITS + 1;
	localparam int IW = RADIUS_BITS + 1;
	localparam int EW = RADIUS_BITS + 3;

	logic                          valid_s1;
	logic                          type_s1;
	logic signed [COORD_BITS-1:0]  cx_s1;
	logic signed [COORD_BITS-1:0]  cy_s1;
	logic        [RADIUS_BITS-1:0] rad_s1;

	logic signed [COORD_BITS-1:0]  cx_q;
	logic signed [COORD_BITS-1:0]  cy_q;
	logic        [RADIUS_BITS-1:0] rad_q;
	logic signed [XW-1:0]          walk_x_q;
	logic        [RADIUS_BITS-1:0] walk_y_q;
	logic        [IW-1:0]          x_inc_q;
	logic        [IW-1:0]          y_inc_q;
	logic signed [EW-1:0]          err_q;
	logic                          active_q;

	logic                          is_step;
	logic                          fire;
	logic                          e_le;
	logic                          e_gt;
	logic signed [EW-1:0]          err_1;
	logic signed [EW-1:0]          err_2;
	logic        [RADIUS_BITS-1:0] y_1;
	logic        [IW-1:0]          yi_1;
	logic        [IW-1:0]          xi_1;
	logic signed [XW-1:0]          x_1;
	logic                          done_1;

	assign is_step     = (type_s1 == mcr_pkg::REQ_STEP) && active_q;
	assign fire        = valid_s1 && (!is_step || rec_free);
	assign in_ch.ready = !valid_s1 || fire;

	// one midpoint update
	always_comb begin
		e_le  = (err_q <= $signed(EW'(0)));
		err_1 = e_le ? err_q + $signed({2'b00, y_inc_q}) : err_q;
		y_1   = walk_y_q + RADIUS_BITS'(e_le);
		yi_1  = e_le ? y_inc_q + IW'(2) : y_inc_q;
		e_gt  = (err_1 > $signed(EW'(0)));
		xi_1  = e_gt ? x_inc_q + IW'(2) : x_inc_q;
		x_1   = e_gt ? walk_x_q - $signed(XW'(1)) : walk_x_q;
		err_2 = e_gt ? err_1 + $signed({2'b00, xi_1}) - $signed({2'b00, rad_q, 1'b0}) : err_1;
		done_1 = (x_1 < $signed({1'b0, y_1}));
	end

	assign rec_ctl.load = fire && is_step;
	assign rec_ctl.done = done_1;
	assign rec_cx       = cx_q;
	assign rec_cy       = cy_q;
	assign rec_x        = walk_x_q[RADIUS_BITS-1:0];
	assign rec_y        = walk_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			type_s1 <= in_ch.req_type;
			cx_s1   <= in_ch.origin_x;
			cy_s1   <= in_ch.origin_y;
			rad_s1  <= in_ch.radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			rad_q    <= '0;
			walk_x_q <= '0;
			walk_y_q <= '0;
			x_inc_q  <= IW'(1);
			y_inc_q  <= IW'(1);
			err_q    <= '0;
			active_q <= 1'b0;
		end else if (fire) begin
			if (type_s1 == mcr_pkg::REQ_START) begin
				cx_q     <= cx_s1;
				cy_q     <= cy_s1;
				rad_q    <= rad_s1;
				walk_x_q <= $signed({1'b0, rad_s1}) - $signed(XW'(1));
				walk_y_q <= '0;
				x_inc_q  <= IW'(1);
				y_inc_q  <= IW'(1);
				err_q    <= $signed(EW'(1)) - $signed({2'b00, rad_s1, 1'b0});
				active_q <= (rad_s1 != '0);
			end else if (active_q) begin
				walk_x_q <= x_1;
				walk_y_q <= y_1;
				x_inc_q  <= xi_1;
				y_inc_q  <= yi_1;
				err_q    <= err_2;
				active_q <= !done_1;
			end
		end
	end

endmodule

### sv/mcr_emit.sv
// ----------------------------------------------------------------------------
// mcr_emit
// Step record register; walks the eight mirrored points onto the output.
// ----------------------------------------------------------------------------
module mcr_emit #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcr_pkg::rec_ctl_t             rec_ctl,
	input  logic signed [COORD_BITS-1:0]  rec_cx,
	input  logic signed [COORD_BITS-1:0]  rec_cy,
	input  logic        [RADIUS_BITS-1:0] rec_x,
	input  logic        [RADIUS_BITS-1:0] rec_y,
	output logic                          rec_free,
	mcr_out_if.source                     out_ch
);
	localparam int OB = COORD_BITS + 1;
	localparam int WW = (OB > RADIUS_BITS + 1) ? OB : RADIUS_BITS + 1;

	logic                          valid_q;
	logic                          done_q;
	logic [mcr_pkg::OCT_BITS-1:0]  oct_q;
	logic signed [COORD_BITS-1:0]  cx_q;
	logic signed [COORD_BITS-1:0]  cy_q;
	logic        [RADIUS_BITS-1:0] x_q;
	logic        [RADIUS_BITS-1:0] y_q;

	logic                          last;
	logic [RADIUS_BITS-1:0]        u;
	logic [RADIUS_BITS-1:0]        v;
	logic signed [WW-1:0]          u_w;
	logic signed [WW-1:0]          v_w;
	logic signed [WW-1:0]          px_w;
	logic signed [WW-1:0]          py_w;

	assign last     = (oct_q == mcr_pkg::OCT_LAST);
	assign rec_free = !valid_q || (out_ch.ready && last);

	// octant bit 2 swaps x/y, bit 1 negates the column term, bit 0 picks +row
	always_comb begin
		u    = oct_q[2] ? y_q : x_q;
		v    = oct_q[2] ? x_q : y_q;
		u_w  = $signed({{(WW-RADIUS_BITS){1'b0}}, u});
		v_w  = $signed({{(WW-RADIUS_BITS){1'b0}}, v});
		px_w = $signed({{(WW-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q})
			+ (oct_q[1] ? -u_w : u_w);
		py_w = $signed({{(WW-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q})
			+ (oct_q[0] ? v_w : -v_w);
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.point_x      = px_w[OB-1:0];
	assign out_ch.point_y      = py_w[OB-1:0];
	assign out_ch.octant       = oct_q;
	assign out_ch.last_of_step = last;
	assign out_ch.circle_done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			oct_q   <= mcr_pkg::OCT_FIRST;
		end else if (rec_ctl.load) begin
			valid_q <= 1'b1;
			oct_q   <= mcr_pkg::OCT_FIRST;
		end else if (valid_q && out_ch.ready) begin
			oct_q <= oct_q + 1'b1;
			if (last) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ctl.load) begin
			cx_q   <= rec_cx;
			cy_q   <= rec_cy;
			x_q    <= rec_x;
			y_q    <= rec_y;
			done_q <= rec_ctl.done;
		end
	end

endmodule
